>>> hdl/pbu_pkg.sv
// Package with opcodes, option-bit positions and item types for the branch unit.
package pbu_pkg;

  // Instruction codes carried in the opcode field.
  typedef enum logic [3:0] {
    OP_B       = 4'd0,
    OP_BC      = 4'd1,
    OP_BCLR    = 4'd2,
    OP_BCCTR   = 4'd3,
    OP_CRAND   = 4'd4,
    OP_CRANDC  = 4'd5,
    OP_CREQV   = 4'd6,
    OP_CRNAND  = 4'd7,
    OP_CRNOR   = 4'd8,
    OP_CROR    = 4'd9,
    OP_CRORC   = 4'd10,
    OP_CRXOR   = 4'd11,
    OP_SET_CTR = 4'd12,
    OP_SET_LR  = 4'd13,
    OP_SET_CR  = 4'd14
  } op_e;

  // Bit positions inside the BO field.
  localparam int unsigned BoSkipCr   = 4;
  localparam int unsigned BoCrSense  = 3;
  localparam int unsigned BoSkipCtr  = 2;
  localparam int unsigned BoCtrSense = 1;

  // Address increment to the sequential instruction.
  localparam logic [31:0] InstrBytes = 32'd4;

  // One instruction to execute.
  typedef struct packed {
    logic [3:0]         opcode;
    logic [31:0]        current_address;
    logic signed [23:0] displacement;
    logic [4:0]         branch_options;
    logic [4:0]         cond_bit_index;
    logic               absolute;
    logic               link;
    logic [4:0]         src_bit_a;
    logic [4:0]         src_bit_b;
    logic [4:0]         dest_bit;
    logic [63:0]        write_value;
  } in_item_t;

  // Outcome of one instruction.
  typedef struct packed {
    logic [31:0] next_address;
    logic        taken;
    logic [63:0] ctr_value;
    logic [63:0] lr_value;
    logic [31:0] cr_value;
  } out_item_t;

endpackage

>>> hdl/pbu_if.sv
// Valid/ready channel interfaces for the branch unit's input and result items.
interface pbu_in_if;
  import pbu_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pbu_out_if;
  import pbu_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/powerpc_branch_unit.sv
// Each item passes the input register and then the result register, where its result waits to be read.
// Throughput: one item per cycle while out_o.ready is high; CTR, LR and CR update as an item
// leaves the input register, so the following item in the input register already sees
// the new values. The result register decouples the sides: one more item is taken into the
// empty input register while a result waits. Reset (rst_ni low, asynchronous) empties both
// stages and clears CTR, LR and CR to zero.
module powerpc_branch_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbu_in_if.sink    in_i,
  pbu_out_if.source out_o
);
  import pbu_pkg::*;

  logic        in_valid_q;
  in_item_t    in_q;
  logic        out_valid_q;
  out_item_t   res_q;
  out_item_t   res_d;
  logic        advance;
  logic [63:0] ctr_q, ctr_d;
  logic [63:0] lr_q, lr_d;
  logic [31:0] cr_q, cr_d;

  // Handshake: the input stage moves on when the result register is free or being read.
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = res_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.payload;
    end
  end

  // Execute the instruction held in the input register.
  always_comb begin
    logic [31:0] seq;
    logic [31:0] offs;
    logic [31:0] target;
    logic [63:0] ctr_dec;
    logic        ctr_ok;
    logic        cond_ok;
    logic        taken;
    logic        bit_a;
    logic        bit_b;
    logic        bit_r;

    seq     = in_q.current_address + InstrBytes;
    offs    = {{6{in_q.displacement[23]}}, in_q.displacement, 2'b00};
    ctr_dec = ctr_q - 64'd1;
    ctr_ok  = in_q.branch_options[BoSkipCtr] ? 1'b1 :
              ((ctr_dec != 64'd0) ^ in_q.branch_options[BoCtrSense]);
    cond_ok = in_q.branch_options[BoSkipCr] ? 1'b1 :
              (cr_q[~in_q.cond_bit_index] == in_q.branch_options[BoCrSense]);
    bit_a   = cr_q[~in_q.src_bit_a];
    bit_b   = cr_q[~in_q.src_bit_b];
    target  = in_q.absolute ? offs : (in_q.current_address + offs);
    taken   = 1'b0;
    bit_r   = 1'b0;
    ctr_d   = ctr_q;
    lr_d    = lr_q;
    cr_d    = cr_q;

    case (in_q.opcode)
      OP_B: begin
        taken = 1'b1;
      end
      OP_BC: begin
        if (!in_q.branch_options[BoSkipCtr]) ctr_d = ctr_dec;
        taken = ctr_ok && cond_ok;
      end
      OP_BCLR: begin
        if (!in_q.branch_options[BoSkipCtr]) ctr_d = ctr_dec;
        taken  = ctr_ok && cond_ok;
        target = lr_q[31:0];
      end
      OP_BCCTR: begin
        taken  = cond_ok;
        target = ctr_q[31:0];
      end
      OP_SET_CTR: ctr_d = in_q.write_value;
      OP_SET_LR:  lr_d  = in_q.write_value;
      OP_SET_CR:  cr_d  = in_q.write_value[31:0];
      OP_CRAND, OP_CRANDC, OP_CREQV, OP_CRNAND,
      OP_CRNOR, OP_CROR, OP_CRORC, OP_CRXOR: begin
        case (in_q.opcode)
          OP_CRAND:  bit_r = bit_a & bit_b;
          OP_CRANDC: bit_r = bit_a & ~bit_b;
          OP_CREQV:  bit_r = ~(bit_a ^ bit_b);
          OP_CRNAND: bit_r = ~(bit_a & bit_b);
          OP_CRNOR:  bit_r = ~(bit_a | bit_b);
          OP_CROR:   bit_r = bit_a | bit_b;
          OP_CRORC:  bit_r = bit_a | ~bit_b;
          default:   bit_r = bit_a ^ bit_b;
        endcase
        cr_d[~in_q.dest_bit] = bit_r;
      end
      default: ;
    endcase

    // Branches with the link bit save the return address after LR was read.
    if ((in_q.opcode == OP_B || in_q.opcode == OP_BC || in_q.opcode == OP_BCLR ||
         in_q.opcode == OP_BCCTR) && in_q.link) begin
      lr_d = {32'd0, seq};
    end

    res_d.next_address = (taken ? target : seq) & ~32'd3;
    res_d.taken        = taken;
    res_d.ctr_value    = ctr_d;
    res_d.lr_value     = lr_d;
    res_d.cr_value     = cr_d;
  end

  // Architectural registers and the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q       <= 64'd0;
      lr_q        <= 64'd0;
      cr_q        <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        ctr_q <= ctr_d;
        lr_q  <= lr_d;
        cr_q  <= cr_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Non-branch instructions never report a taken branch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.opcode > OP_BCCTR) |-> !res_d.taken)
    else $error("non-branch item reported as taken");

  // Every delivered next address is word aligned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.next_address[1:0] == 2'b00))
    else $error("next address not word aligned");

  // The count register only moves when an item is executed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(ctr_q))
    else $error("count register changed without an item");

  // A set-CTR item loads its value into the count register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.opcode == OP_SET_CTR) |=> (ctr_q == $past(in_q.write_value)))
    else $error("set CTR did not load the count register");

endmodule

>>> tb/pbu_branch_checker.sv
// Checker that predicts the branch unit's result items and compares them with the DUT.
`timescale 1ns / 1ps
module pbu_branch_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pbu_in_if    instr_i,
  pbu_out_if   result_i,
  output int   fail_count_o,
  output int   pending_o
);
  import pbu_pkg::*;

  localparam logic [31:0] AddrAlignMask = ~32'h3;

  // Shadow copies of the count, link and condition registers.
  logic [63:0] ctr_q;
  logic [63:0] lr_q;
  logic [31:0] cr_q;

  // Predicted result items, oldest first.
  out_item_t   predicted_results[$];
  out_item_t   oldest;

  // CR bit 0 is the most significant bit of the register.
  function automatic logic cr_bit(logic [4:0] idx);
    return cr_q[5'd31 - idx];
  endfunction

  // Decrement and test CTR unless the options say to skip it.
  function automatic logic ctr_cond(logic [4:0] bo);
    if (bo[BoSkipCtr]) return 1'b1;
    ctr_q = ctr_q - 64'd1;
    return (ctr_q != 64'd0) ^ bo[BoCtrSense];
  endfunction

  // Compare the selected CR bit with the sense bit unless the test is skipped.
  function automatic logic cr_cond(logic [4:0] bo, logic [4:0] bi);
    if (bo[BoSkipCr]) return 1'b1;
    return cr_bit(bi) == bo[BoCrSense];
  endfunction

  // Execute one instruction on the shadow registers and return its result item.
  function automatic out_item_t execute_instr(in_item_t it);
    logic [31:0] seq_addr;
    logic [31:0] offset;
    logic [31:0] target;
    logic        taken;
    logic        bit_a;
    logic        bit_b;
    logic        bit_r;
    logic        is_cr_op;
    out_item_t   res;
    seq_addr = it.current_address + InstrBytes;
    offset   = {{6{it.displacement[23]}}, it.displacement, 2'b00};
    target   = '0;
    taken    = 1'b0;
    bit_r    = 1'b0;
    is_cr_op = 1'b1;
    bit_a    = cr_bit(it.src_bit_a);
    bit_b    = cr_bit(it.src_bit_b);
    case (it.opcode)
      OP_B: begin
        target   = it.absolute ? offset : it.current_address + offset;
        taken    = 1'b1;
        is_cr_op = 1'b0;
      end
      OP_BC: begin
        target   = it.absolute ? offset : it.current_address + offset;
        taken    = ctr_cond(it.branch_options) & cr_cond(it.branch_options, it.cond_bit_index);
        is_cr_op = 1'b0;
      end
      OP_BCLR: begin
        target   = lr_q[31:0];
        taken    = ctr_cond(it.branch_options) & cr_cond(it.branch_options, it.cond_bit_index);
        is_cr_op = 1'b0;
      end
      OP_BCCTR: begin
        target   = ctr_q[31:0];
        taken    = cr_cond(it.branch_options, it.cond_bit_index);
        is_cr_op = 1'b0;
      end
      OP_CRAND:  bit_r = bit_a & bit_b;
      OP_CRANDC: bit_r = bit_a & ~bit_b;
      OP_CREQV:  bit_r = ~(bit_a ^ bit_b);
      OP_CRNAND: bit_r = ~(bit_a & bit_b);
      OP_CRNOR:  bit_r = ~(bit_a | bit_b);
      OP_CROR:   bit_r = bit_a | bit_b;
      OP_CRORC:  bit_r = bit_a | ~bit_b;
      OP_CRXOR:  bit_r = bit_a ^ bit_b;
      OP_SET_CTR: begin
        ctr_q    = it.write_value;
        is_cr_op = 1'b0;
      end
      OP_SET_LR: begin
        lr_q     = it.write_value;
        is_cr_op = 1'b0;
      end
      OP_SET_CR: begin
        cr_q     = it.write_value[31:0];
        is_cr_op = 1'b0;
      end
      default: is_cr_op = 1'b0;
    endcase
    if (is_cr_op) cr_q[5'd31 - it.dest_bit] = bit_r;
    // Branches write the return address after the target has been taken from LR.
    if (it.opcode <= OP_BCCTR && it.link) lr_q = {32'd0, seq_addr};
    res.next_address = (taken ? target : seq_addr) & AddrAlignMask;
    res.taken        = taken;
    res.ctr_value    = ctr_q;
    res.lr_value     = lr_q;
    res.cr_value     = cr_q;
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  // Compare each result item with the oldest prediction, then predict for a new instruction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q        = '0;
      lr_q         = '0;
      cr_q         = '0;
      fail_count_o = 0;
      predicted_results.delete();
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result item arrived with no instruction outstanding");
          fail_count_o++;
        end else begin
          oldest = predicted_results.pop_front();
          check_field("next_address", 64'(oldest.next_address),
                      64'(result_i.payload.next_address));
          check_field("taken", 64'(oldest.taken), 64'(result_i.payload.taken));
          check_field("ctr_value", oldest.ctr_value, result_i.payload.ctr_value);
          check_field("lr_value", oldest.lr_value, result_i.payload.lr_value);
          check_field("cr_value", 64'(oldest.cr_value), 64'(result_i.payload.cr_value));
        end
      end
      if (instr_i.valid && instr_i.ready) begin
        predicted_results.push_back(execute_instr(instr_i.payload));
      end
    end
    pending_o = predicted_results.size();
  end

endmodule

>>> tb/tb_powerpc_branch_unit.sv
// Testbench top for the branch unit: clock, reset, instruction stimulus and the verdict.
`timescale 1ns / 1ps
module tb_powerpc_branch_unit;
  import pbu_pkg::*;

  // Opcode value that the block decodes as no operation.
  localparam logic [3:0] OpUnused     = 4'd15;
  localparam int         RandomItems  = 1450;
  localparam int         LongHoldOff  = 60;
  localparam int         QuietFrom    = 1300;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   quiet_phase;
  int   hold_request;
  int   gap_pct;

  pbu_in_if  instr_ch ();
  pbu_out_if result_ch ();

  powerpc_branch_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (instr_ch),
    .out_o  (result_ch)
  );

  pbu_branch_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .instr_i      (instr_ch),
    .result_i     (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 4 ns clock.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Instruction with every field random; callers override what matters.
  function automatic in_item_t random_item(logic [3:0] op);
    in_item_t it;
    it.opcode          = op;
    it.current_address = $urandom;
    it.displacement    = 24'($urandom);
    it.branch_options  = 5'($urandom);
    it.cond_bit_index  = 5'($urandom);
    it.absolute        = 1'($urandom);
    it.link            = 1'($urandom);
    it.src_bit_a       = 5'($urandom);
    it.src_bit_b       = 5'($urandom);
    it.dest_bit        = 5'($urandom);
    it.write_value     = {$urandom, $urandom};
    return it;
  endfunction

  task automatic idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      instr_ch.valid <= 1'b0;
    end
  endtask

  // Offer one instruction until it is accepted, then maybe leave a gap.
  task automatic issue(in_item_t it);
    @(negedge clk_i);
    instr_ch.valid   <= 1'b1;
    instr_ch.payload <= it;
    do @(posedge clk_i); while (!instr_ch.ready);
    if (!quiet_phase && $urandom_range(0, 99) < gap_pct) idle_sender($urandom_range(1, 11));
  endtask

  // Stop offering and wait until every predicted result item has come back.
  task automatic drain_results();
    do begin
      @(negedge clk_i);
      instr_ch.valid <= 1'b0;
    end while (pending != 0);
  endtask

  // Stimulus: directed instructions, then a long random stream.
  initial begin
    in_item_t it;
    int       pick;
    instr_ch.valid   = 1'b0;
    instr_ch.payload = '0;
    rst_ni           = 1'b0;
    quiet_phase      = 1'b0;
    hold_request     = 0;
    gap_pct          = 20;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Unconditional branches at the displacement extremes and across the address wrap.
    it = random_item(OP_B);
    it.displacement = 24'sh7FFFFF;
    it.absolute = 1'b0;
    it.link = 1'b0;
    issue(it);
    it = random_item(OP_B);
    it.displacement = 24'sh800000;
    it.absolute = 1'b1;
    it.link = 1'b1;
    issue(it);
    it = random_item(OP_B);
    it.current_address = 32'hFFFF_FFFF;
    it.displacement = '0;
    it.absolute = 1'b0;
    it.link = 1'b1;
    issue(it);

    // Conditional branches: CTR running down to zero, wrapping, and both CR senses.
    it = random_item(OP_SET_CR);
    it.write_value = 64'hFFFF_FFFF_A5A5_0F0F;
    issue(it);
    it = random_item(OP_SET_CTR);
    it.write_value = 64'd2;
    issue(it);
    it = random_item(OP_BC);
    it.branch_options = 5'b00000;
    it.cond_bit_index = 5'd0;
    issue(it);
    it = random_item(OP_BC);
    it.branch_options = 5'b10000;
    issue(it);
    it = random_item(OP_BC);
    it.branch_options = 5'b10010;
    issue(it);
    it = random_item(OP_SET_CTR);
    it.write_value = 64'd1;
    issue(it);
    it = random_item(OP_BC);
    it.branch_options = 5'b10010;
    it.absolute = 1'b0;
    issue(it);
    it = random_item(OP_BC);
    it.branch_options = 5'b10100;
    it.absolute = 1'b1;
    issue(it);
    it = random_item(OP_BC);
    it.branch_options = 5'b01100;
    it.cond_bit_index = 5'd0;
    it.absolute = 1'b0;
    issue(it);

    // Branch to LR, with the link written after the target is taken.
    it = random_item(OP_SET_LR);
    it.write_value = 64'hDEAD_BEEF_1234_5677;
    issue(it);
    it = random_item(OP_BCLR);
    it.branch_options = 5'b10100;
    it.link = 1'b1;
    issue(it);
    it = random_item(OP_BCLR);
    it.branch_options = 5'b00000;
    it.cond_bit_index = 5'd31;
    it.link = 1'b0;
    issue(it);

    // Branch to CTR, which never touches CTR itself.
    it = random_item(OP_SET_CTR);
    it.write_value = '1;
    issue(it);
    it = random_item(OP_BCCTR);
    it.branch_options = 5'b00000;
    it.cond_bit_index = 5'd4;
    issue(it);
    it = random_item(OP_BCCTR);
    it.branch_options = 5'b10000;
    it.link = 1'b1;
    issue(it);

    // Every CR logic operation, once with the destination equal to a source.
    for (int k = 0; k < 8; k++) begin
      it = random_item(4'(OP_CRAND + k));
      if (k == 0) it.dest_bit = it.src_bit_a;
      issue(it);
    end

    // The unused opcode leaves every register alone.
    issue(random_item(OpUnused));

    // Random stream, weighted toward branches and CR logic.
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) begin
        pick = $urandom_range(0, 2);
        gap_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 30;
      end
      if (i == 300) hold_request = LongHoldOff;
      if (i == 700) drain_results();
      if (i == QuietFrom) quiet_phase = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) it = random_item(4'($urandom_range(OP_B, OP_BCCTR)));
      else if (pick < 75) it = random_item(4'($urandom_range(OP_CRAND, OP_CRXOR)));
      else if (pick < 97) it = random_item(4'($urandom_range(OP_SET_CTR, OP_SET_CR)));
      else it = random_item(OpUnused);
      // Small CTR values make the decrement reach zero often.
      if (it.opcode == OP_SET_CTR && $urandom_range(0, 9) < 6) begin
        it.write_value = 64'($urandom_range(0, 3));
      end
      if ($urandom_range(0, 9) == 0) begin
        it.displacement = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      end
      issue(it);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: random stall bursts, one long hold-off, and always ready near the end.
  initial begin
    int stall_pct;
    int cycle_cnt;
    int hold_len;
    result_ch.ready = 1'b0;
    stall_pct = 20;
    cycle_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cycle_cnt++;
      if (cycle_cnt % 128 == 0) stall_pct = $urandom_range(0, 2) * 15;
      if (hold_request > 0) begin
        hold_len = hold_request;
        hold_request = 0;
        result_ch.ready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk_i);
      end else if (!quiet_phase && $urandom_range(0, 99) < stall_pct) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk_i);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
hdl/pbu_pkg.sv
hdl/pbu_if.sv
hdl/powerpc_branch_unit.sv
tb/pbu_branch_checker.sv
tb/tb_powerpc_branch_unit.sv
